[rtl/core/assoc_store_age_depth_replace_macros.svh]
// Assertion macros used by the port-level checker of the associative store.
`ifndef ASSOC_STORE_AGE_DEPTH_REPLACE_MACROS_SVH
`define ASSOC_STORE_AGE_DEPTH_REPLACE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ASRT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define ASRT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/asadr_pkg.sv]
// Shared constants, types and entry layout of the associative store.
package asadr_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int WAYS          = 4;
	localparam int STORE_DEPTH   = TABLE_ENTRIES + WAYS - 1;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int WAY_W         = 2;

	localparam int KEY_W   = 64;
	localparam int MOVE_W  = 15;
	localparam int DEPTH_W = 8;
	localparam int VAL_W   = 16;
	localparam int AGE_W   = 8;
	localparam int PL_W    = DEPTH_W + MOVE_W + VAL_W + AGE_W;
	localparam int ENTRY_W = KEY_W + PL_W;

	localparam int PL_DEPTH_LSB = 0;
	localparam int PL_AGE_LSB   = DEPTH_W + MOVE_W + VAL_W;

	localparam int SCORE_W   = 16;
	localparam int REPL_BIAS = 256;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCORE_MODE  = 1'b0,
		REG_CURRENT_AGE = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	// Control from the sequencer to the shared score unit.
	typedef struct packed {
		logic             eval;
		logic             first;
		logic [WAY_W-1:0] way;
	} score_ctl_t;

	function automatic logic [PL_W-1:0] pack_payload(
		input logic [DEPTH_W-1:0] depth,
		input logic [MOVE_W-1:0]  mv,
		input logic [VAL_W-1:0]   val,
		input logic [AGE_W-1:0]   age
	);
		return {age, val, mv, depth};
	endfunction

endpackage

[rtl/core/asadr_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
module asadr_ram #(
	parameter int DW    = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/asadr_score.sv]
// Replacement score of one candidate per cycle and running best-way tracker.
module asadr_score (
	input  logic                                clk,
	input  logic                                arst_n,
	input  asadr_pkg::score_ctl_t               ctl,
	input  logic                                mode,
	input  logic [asadr_pkg::AGE_W-1:0]         cur_age,
	input  logic [asadr_pkg::AGE_W-1:0]         entry_age,
	input  logic [asadr_pkg::DEPTH_W-1:0]       entry_depth,
	output logic [asadr_pkg::WAY_W-1:0]         pick_way
);
	import asadr_pkg::*;

	logic [AGE_W-1:0]   fwd;
	logic [AGE_W-1:0]   back;
	logic [AGE_W-1:0]   near;
	logic [SCORE_W-1:0] val;
	logic [SCORE_W-1:0] best_ref;
	logic [WAY_W-1:0]   way_ref;
	logic               better;
	logic [SCORE_W-1:0] best_q;
	logic [WAY_W-1:0]   best_way_q;

	always_comb begin
		fwd  = cur_age - entry_age;
		back = entry_age - cur_age;
		near = (fwd < back) ? fwd : back;
		if (mode) begin
			// Three times the circular distance, built as a shift and an add.
			val = SCORE_W'({near, 1'b0}) + SCORE_W'(near) + SCORE_W'(REPL_BIAS)
				- SCORE_W'(entry_depth);
		end else begin
			// For an 8-bit depth, 255 minus depth is its complement.
			val = {fwd, ~entry_depth};
		end
		best_ref = ctl.first ? '0 : best_q;
		way_ref  = ctl.first ? '0 : best_way_q;
		better   = val > best_ref;
		pick_way = better ? ctl.way : way_ref;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			best_way_q <= '0;
		end else if (ctl.eval) begin
			best_q     <= better ? val : best_ref;
			best_way_q <= pick_way;
		end
	end

endmodule

[rtl/core/assoc_store_age_depth_replace.sv]
// Top level of the four-way associative store with age/depth replacement.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  req     | req_valid, req_stall | key, best_move, search_depth, score
//  rsp     | rsp_valid, rsp_stall | hit, way
//  cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// After reset a clearing pass writes zero to all 1027 entries, one per cycle, and
// requests are stalled while it runs; configuration writes are taken throughout.
// A word reads one entry per cycle from the single table RAM and scores it in the
// shared score unit, then writes one entry: the hit way, or on a miss the best way.
// The final write waits while the response register holds an untaken word.
module assoc_store_age_depth_replace (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [asadr_pkg::KEY_W-1:0]         key,
	input  logic [asadr_pkg::MOVE_W-1:0]        best_move,
	input  logic [asadr_pkg::DEPTH_W-1:0]       search_depth,
	input  logic signed [asadr_pkg::VAL_W-1:0]  score,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic                                hit,
	output logic [asadr_pkg::WAY_W-1:0]         way,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [asadr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [asadr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import asadr_pkg::*;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [WAY_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    start_q;
	logic [KEY_W-1:0]    key_q;
	logic [MOVE_W-1:0]   move_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [VAL_W-1:0]    val_q;
	logic                hit_found_q;
	logic [WAY_W-1:0]    wr_way_q;
	logic                score_mode_q;
	logic [AGE_W-1:0]    current_age_q;
	logic                rsp_valid_q;
	logic                rsp_hit_q;
	logic [WAY_W-1:0]    rsp_way_q;

	logic                accept;
	logic                rsp_free;
	logic [IDX_W-1:0]    start_in;
	logic [WAY_W-1:0]    rd_way;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;
	logic [KEY_W-1:0]    ent_key;
	logic [PL_W-1:0]     ent_pl;
	logic                key_match;
	logic                last_way;
	score_ctl_t          sctl;
	logic [WAY_W-1:0]    pick_way;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign hit       = rsp_hit_q;
	assign way       = rsp_way_q;

	assign start_in  = key[IDX_W-1:0] & IDX_W'(TABLE_ENTRIES - 1);
	assign rd_way    = cnt_q + 1'b1;
	assign ent_key   = ram_rdata[ENTRY_W-1 -: KEY_W];
	assign ent_pl    = ram_rdata[PL_W-1:0];
	assign key_match = (ent_key == key_q);
	assign last_way  = (cnt_q == WAY_W'(WAYS - 1));

	// The first way is read in the accept cycle, so each scan cycle sees the
	// data of way cnt_q while it requests way cnt_q + 1.
	always_comb begin
		ram_raddr = ADDR_W'(start_q) + ADDR_W'(rd_way);
		if (state_q == ST_IDLE) begin
			ram_raddr = ADDR_W'(start_in);
		end
		ram_we    = 1'b0;
		ram_waddr = ADDR_W'(start_q) + ADDR_W'(wr_way_q);
		ram_wdata = {key_q, pack_payload(depth_q, move_q, val_q, current_age_q)};
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_WRITE: begin
				ram_we = rsp_free;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		sctl.eval  = (state_q == ST_SCAN) && !key_match;
		sctl.first = (cnt_q == '0);
		sctl.way   = cnt_q;
	end

	asadr_ram #(
		.DW    (ENTRY_W),
		.DEPTH (STORE_DEPTH),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	asadr_score u_score (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (sctl),
		.mode        (score_mode_q),
		.cur_age     (current_age_q),
		.entry_age   (ent_pl[PL_AGE_LSB +: AGE_W]),
		.entry_depth (ent_pl[PL_DEPTH_LSB +: DEPTH_W]),
		.pick_way    (pick_way)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_mode_q  <= 1'b0;
			current_age_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCORE_MODE:  score_mode_q  <= cfg_data[0];
				REG_CURRENT_AGE: current_age_q <= cfg_data[AGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			hit_found_q <= 1'b0;
			wr_way_q    <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (key_match) begin
						hit_found_q <= 1'b1;
						wr_way_q    <= cnt_q;
						state_q     <= ST_WRITE;
					end else if (last_way) begin
						hit_found_q <= 1'b0;
						wr_way_q    <= pick_way;
						state_q     <= ST_WRITE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WRITE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A new response word takes the register as the old one leaves it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_WRITE) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Word and response payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_in;
			key_q   <= key;
			move_q  <= best_move;
			depth_q <= search_depth;
			val_q   <= score;
		end
		if ((state_q == ST_WRITE) && rsp_free) begin
			rsp_hit_q <= hit_found_q;
			rsp_way_q <= wr_way_q;
		end
	end

endmodule

[rtl/core/asadr_chk.sv]
// Port-level checker for the associative store, bound to the top level.
`include "assoc_store_age_depth_replace_macros.svh"

module asadr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic        hit,
	input logic [1:0]  way,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// A stalled response word keeps its payload.
	`ASRT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, $stable(hit) && $stable(way))

	// The table scan and the final write hold off new words.
	`ASRT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall ##1 req_stall)

	// A response appears only at the end of a scan, while requests were stalled.
	`ASRT_NOW(a_rsp_after_scan, $rose(rsp_valid), $past(req_stall))

	// Register writes are never held off.
	`ASRT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind assoc_store_age_depth_replace asadr_chk u_asadr_chk (.*);
